// ----- hdl/mads_pkg.sv -----
// ----------------------------------------------------------------------------
// mads_pkg
// Shared widths, phase encoding and store port types for the mux ADC scanner.
// ----------------------------------------------------------------------------
package mads_pkg;

  localparam int unsigned ChanW   = 3;
  localparam int unsigned SampleW = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned SettleW = 8;

  localparam logic [SettleW-1:0] SettleReset = 8'd1;

  typedef enum logic [1:0] {
    PhSelect  = 2'd0,
    PhSettle  = 2'd1,
    PhDummy   = 2'd2,
    PhConvert = 2'd3
  } phase_e;

  typedef struct packed {
    logic               en;
    logic [ChanW-1:0]   idx;
    logic [SampleW-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic [SampleW-1:0] value;
    logic               valid;
  } store_rd_t;

endpackage

// ----- hdl/mads_if.sv -----
// ----------------------------------------------------------------------------
// mads_if
// Valid/ready channels for poll step items and scanner result items.
// ----------------------------------------------------------------------------
interface mads_in_if;
  logic                        valid;
  logic                        ready;
  logic [mads_pkg::TimeW-1:0]   now_ms;
  logic                        start_accepted;
  logic                        conversion_ready;
  logic [mads_pkg::SampleW-1:0] sample;
  logic [mads_pkg::ChanW-1:0]   query_index;

  modport source (
    output valid, now_ms, start_accepted, conversion_ready, sample, query_index,
    input  ready
  );
  modport sink (
    input  valid, now_ms, start_accepted, conversion_ready, sample, query_index,
    output ready
  );
endinterface

interface mads_out_if;
  logic                        valid;
  logic                        ready;
  logic [mads_pkg::ChanW-1:0]   mux_select;
  logic                        start_request;
  logic                        stop_request;
  logic                        stored;
  logic [mads_pkg::SampleW-1:0] query_value;
  logic                        query_valid;

  modport source (
    output valid, mux_select, start_request, stop_request, stored, query_value,
           query_valid,
    input  ready
  );
  modport sink (
    input  valid, mux_select, start_request, stop_request, stored, query_value,
           query_valid,
    output ready
  );
endinterface

// ----- hdl/mads_store.sv -----
// ----------------------------------------------------------------------------
// mads_store
// Per-channel sample store with valid mask; unwritten entries read as zero.
// ----------------------------------------------------------------------------
module mads_store #(
  parameter int unsigned POT_COUNT = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mads_pkg::store_wr_t             wr_i,
  input  logic [mads_pkg::ChanW-1:0]      rd_idx_i,
  output mads_pkg::store_rd_t             rd_o
);

  localparam int unsigned IdxW = (POT_COUNT > 1) ? $clog2(POT_COUNT) : 1;

  logic [mads_pkg::SampleW-1:0] value_q [POT_COUNT];
  logic [POT_COUNT-1:0]         valid_q;
  logic                         in_range;
  logic [IdxW-1:0]              rd_idx;
  logic [IdxW-1:0]              wr_idx;

  assign rd_idx   = rd_idx_i[IdxW-1:0];
  assign wr_idx   = wr_i.idx[IdxW-1:0];
  assign in_range = {1'b0, rd_idx_i} < (mads_pkg::ChanW + 1)'(POT_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      value_q[wr_idx] <= wr_i.data;
    end
  end

  always_comb begin
    rd_o = '0;
    if (in_range && valid_q[rd_idx]) begin
      rd_o.value = value_q[rd_idx];
      rd_o.valid = 1'b1;
    end
  end

endmodule

// ----- hdl/mux_adc_scan_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// mux_adc_scan_sequencer_core
// Four-phase mux ADC channel scanner, one poll step item in, one result out.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  in_chan   in   valid/ready   now_ms, start_accepted, conversion_ready,
//                               sample, query_index
//  out_chan  out  valid/ready   mux_select, start_request, stop_request,
//                               stored, query_value, query_valid
//  cfg       in   settle_ms_we_i settle_ms_i
//
//  One item per cycle while out_chan takes results; its result is in the output register on the next cycle.
//  Phase, channel and store update at the edge the item is accepted.
//  in_chan.ready is high while the output register is empty or being taken.
//  Reset: select phase, channel 0, valid mask cleared (store data not reset), settle 1 ms.
// ----------------------------------------------------------------------------
module mux_adc_scan_sequencer_core #(
  parameter int unsigned POT_COUNT = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mads_in_if.sink                        in_chan,
  mads_out_if.source                     out_chan,
  input  logic                           settle_ms_we_i,
  input  logic [mads_pkg::SettleW-1:0]   settle_ms_i
);

  localparam int unsigned CntW = mads_pkg::ChanW + 1;

  logic [mads_pkg::SettleW-1:0] settle_ms_q;
  mads_pkg::phase_e             phase_q, phase_d;
  logic [mads_pkg::ChanW-1:0]   channel_q, channel_d;
  logic [mads_pkg::TimeW-1:0]   settle_start_q, settle_start_d;
  logic [mads_pkg::ChanW-1:0]   mux_q, mux_d;

  logic                         accept;
  logic [mads_pkg::TimeW-1:0]   elapsed;
  logic                         settled;
  logic [CntW-1:0]              chan_inc;
  logic [mads_pkg::ChanW-1:0]   chan_next;
  logic                         start_req, stop_req, stored;
  mads_pkg::store_wr_t          wr;
  mads_pkg::store_rd_t          rd;

  logic                         out_valid_q;
  logic [mads_pkg::ChanW-1:0]   out_mux_q;
  logic                         out_start_q, out_stop_q, out_stored_q;
  logic [mads_pkg::SampleW-1:0] out_qval_q;
  logic                         out_qvalid_q;

  assign in_chan.ready = !out_valid_q || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign elapsed   = in_chan.now_ms - settle_start_q;
  assign settled   = elapsed >= {{(mads_pkg::TimeW - mads_pkg::SettleW){1'b0}}, settle_ms_q};
  assign chan_inc  = {1'b0, channel_q} + CntW'(1);
  assign chan_next = (chan_inc >= CntW'(POT_COUNT)) ? '0 : chan_inc[mads_pkg::ChanW-1:0];

  // next state
  always_comb begin
    phase_d        = phase_q;
    channel_d      = channel_q;
    settle_start_d = settle_start_q;
    mux_d          = mux_q;
    case (phase_q)
      mads_pkg::PhSelect: begin
        mux_d          = channel_q;
        settle_start_d = in_chan.now_ms;
        phase_d        = mads_pkg::PhSettle;
      end
      mads_pkg::PhSettle: begin
        if (settled && in_chan.start_accepted) begin
          phase_d = mads_pkg::PhDummy;
        end
      end
      mads_pkg::PhDummy: begin
        if (in_chan.conversion_ready) begin
          phase_d = in_chan.start_accepted ? mads_pkg::PhConvert : mads_pkg::PhSelect;
        end
      end
      mads_pkg::PhConvert: begin
        if (in_chan.conversion_ready) begin
          channel_d = chan_next;
          phase_d   = mads_pkg::PhSelect;
        end
      end
      default: begin
        phase_d = mads_pkg::PhSelect;
      end
    endcase
  end

  // step outputs
  always_comb begin
    start_req = 1'b0;
    stop_req  = 1'b0;
    stored    = 1'b0;
    case (phase_q)
      mads_pkg::PhSelect: begin
      end
      mads_pkg::PhSettle: begin
        start_req = settled;
      end
      mads_pkg::PhDummy: begin
        start_req = in_chan.conversion_ready;
        stop_req  = in_chan.conversion_ready;
      end
      mads_pkg::PhConvert: begin
        stop_req = in_chan.conversion_ready;
        stored   = in_chan.conversion_ready;
      end
      default: begin
      end
    endcase
  end

  assign wr.en   = accept && stored;
  assign wr.idx  = channel_q;
  assign wr.data = in_chan.sample;

  mads_store #(
    .POT_COUNT (POT_COUNT)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_idx_i (in_chan.query_index),
    .rd_o     (rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_ms_q <= mads_pkg::SettleReset;
    end else if (settle_ms_we_i) begin
      settle_ms_q <= settle_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= mads_pkg::PhSelect;
      channel_q      <= '0;
      settle_start_q <= '0;
      mux_q          <= '0;
    end else if (accept) begin
      phase_q        <= phase_d;
      channel_q      <= channel_d;
      settle_start_q <= settle_start_d;
      mux_q          <= mux_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_chan.ready) begin
      out_valid_q <= in_chan.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_mux_q    <= mux_d;
      out_start_q  <= start_req;
      out_stop_q   <= stop_req;
      out_stored_q <= stored;
      out_qval_q   <= rd.value;
      out_qvalid_q <= rd.valid;
    end
  end

  assign out_chan.valid         = out_valid_q;
  assign out_chan.mux_select    = out_mux_q;
  assign out_chan.start_request = out_start_q;
  assign out_chan.stop_request  = out_stop_q;
  assign out_chan.stored        = out_stored_q;
  assign out_chan.query_value   = out_qval_q;
  assign out_chan.query_valid   = out_qvalid_q;

  a_channel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, channel_q} < CntW'(POT_COUNT))
    else $error("channel out of range");

  a_select_to_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q == mads_pkg::PhSelect |=> phase_q == mads_pkg::PhSettle)
    else $error("select did not move to settle");

  a_store_to_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |=> phase_q == mads_pkg::PhSelect && channel_q != $past(channel_q)
              || POT_COUNT == 1)
    else $error("store did not advance channel");

  a_stored_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |=> out_chan.valid && out_chan.stored && out_chan.stop_request)
    else $error("stored item lost from result");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(phase_q) && $stable(channel_q))
    else $error("state changed without an item");

endmodule
